// ===== rtl/core/selc_pkg.sv =====
package selc_pkg;

	localparam int POS_BITS_DEFAULT = 16;

	localparam logic [1:0] KIND_OP  = 2'd0;
	localparam logic [1:0] KIND_INT = 2'd1;
	localparam logic [1:0] KIND_END = 2'd2;
	localparam logic [1:0] KIND_BAD = 2'd3;

	localparam logic [1:0] ERR_NONE     = 2'd0;
	localparam logic [1:0] ERR_BAD_CHAR = 2'd1;
	localparam logic [1:0] ERR_EXP_INT  = 2'd2;
	localparam logic [1:0] ERR_EXP_OP   = 2'd3;

	localparam logic [7:0] CH_END   = 8'd0;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_TAB   = 8'd9;
	localparam logic [7:0] CH_CR    = 8'd13;
	localparam logic [7:0] CH_SPACE = 8'd32;

	localparam logic [62:0] VALUE_MAX = {63{1'b1}};

endpackage

// ===== rtl/core/sum_expression_lexer_checker_unit.sv =====
// Channel | Handshake           | Payload
// input   | in_valid, in_ready   | char_code
// output  | out_valid, out_ready | token_kind, is_minus, int_value, token_pos,
//         |                      | error_code, error_pos, bad_char, last
//
// One character per cycle unless the scan stage stalls: a registered character
// is scanned and its 0 to 2 tokens are written into a 4-entry output queue.
// The output drains one token per cycle while out_ready is high, so a character
// that yields two tokens outpaces the output side; the queue absorbs that.
// The scan stage stalls while the queue has fewer than two free entries.
// Reset clears the scanner and grammar state and empties the queue.
module sum_expression_lexer_checker_unit #(
	parameter int POS_BITS = selc_pkg::POS_BITS_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  char_code,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  token_kind,
	output logic        is_minus,
	output logic [62:0] int_value,
	output logic [15:0] token_pos,
	output logic [1:0]  error_code,
	output logic [15:0] error_pos,
	output logic [7:0]  bad_char,
	output logic        last
);
	import selc_pkg::*;

	typedef enum logic [2:0] {
		PH_IDLE    = 3'b001,
		PH_NUMBER  = 3'b010,
		PH_DISCARD = 3'b100
	} phase_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic        minus;
		logic [62:0] value;
		logic [15:0] pos;
		logic [1:0]  err;
		logic [15:0] epos;
		logic [7:0]  bad;
		logic        last;
	} result_t;

	localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};

	// input register
	logic [7:0] char_s1;
	logic       valid_s1;

	// scanner state
	phase_t              phase_q, phase_d;
	logic [62:0]         accum_q, accum_d;
	logic [POS_BITS-1:0] nstart_q, nstart_d;
	logic [POS_BITS-1:0] cpos_q, cpos_d;
	logic                expop_q, expop_d;
	logic [1:0]          gerr_q, gerr_d;
	logic [POS_BITS-1:0] gpos_q, gpos_d;

	// output queue
	result_t    fifo_q [4];
	logic [1:0] rd_ptr_q, wr_ptr_q;
	logic [2:0] count_q;

	logic       proc;
	logic       pop;
	logic [1:0] n_res;
	result_t    slot0, slot1;

	function automatic logic [15:0] pos16(input logic [POS_BITS-1:0] p);
		logic [POS_BITS+15:0] w;
		w = {16'd0, p};
		return w[15:0];
	endfunction

	assign proc     = valid_s1 && (count_q <= 3'd2);
	assign in_ready = !valid_s1 || proc;
	assign pop      = out_valid && out_ready;

	always_comb begin
		logic                is_digit;
		logic                is_ws;
		logic                emit_int;
		logic                sec_v;
		logic [66:0]         acc_wide;
		logic [POS_BITS-1:0] pos_inc;
		logic [1:0]          end_err;
		result_t             int_r, sec_r;

		is_digit = (char_s1 >= CH_ZERO) && (char_s1 <= CH_NINE);
		is_ws    = ((char_s1 >= CH_TAB) && (char_s1 <= CH_CR)) || (char_s1 == CH_SPACE);
		pos_inc  = (cpos_q == POS_MAX) ? cpos_q : cpos_q + 1'b1;
		acc_wide = ({4'd0, accum_q} << 3) + ({4'd0, accum_q} << 1) + {63'd0, char_s1[3:0]};

		phase_d  = phase_q;
		accum_d  = accum_q;
		nstart_d = nstart_q;
		cpos_d   = cpos_q;
		expop_d  = expop_q;
		gerr_d   = gerr_q;
		gpos_d   = gpos_q;
		emit_int = 1'b0;
		sec_v    = 1'b0;
		end_err  = ERR_NONE;

		int_r       = '0;
		int_r.kind  = KIND_INT;
		int_r.value = accum_q;
		int_r.pos   = pos16(nstart_q);
		sec_r       = '0;
		sec_r.pos   = pos16(cpos_q);

		if (phase_q == PH_NUMBER && is_digit) begin
			accum_d = (|acc_wide[66:63]) ? VALUE_MAX : acc_wide[62:0];
			cpos_d  = pos_inc;
		end else begin
			if (phase_q == PH_NUMBER) begin
				emit_int = 1'b1;
				if (expop_q && gerr_d == ERR_NONE) begin
					gerr_d = ERR_EXP_OP;
					gpos_d = nstart_q;
				end
				expop_d = 1'b1;
				phase_d = PH_IDLE;
				accum_d = '0;
			end
			if (char_s1 == CH_END) begin
				if (!expop_d && gerr_d == ERR_NONE) begin
					gerr_d = ERR_EXP_INT;
					gpos_d = cpos_q;
				end
				end_err    = gerr_d;
				sec_v      = 1'b1;
				sec_r.kind = KIND_END;
				sec_r.err  = end_err;
				sec_r.epos = (end_err != ERR_NONE) ? pos16(gpos_d) : 16'd0;
				phase_d    = PH_IDLE;
				accum_d    = '0;
				nstart_d   = '0;
				cpos_d     = '0;
				expop_d    = 1'b0;
				gerr_d     = ERR_NONE;
				gpos_d     = '0;
			end else begin
				if (phase_d == PH_DISCARD || is_ws) begin
					sec_v = 1'b0;
				end else if (char_s1 == CH_PLUS || char_s1 == CH_MINUS) begin
					sec_v       = 1'b1;
					sec_r.kind  = KIND_OP;
					sec_r.minus = (char_s1 == CH_MINUS);
					if (!expop_d && gerr_d == ERR_NONE) begin
						gerr_d = ERR_EXP_INT;
						gpos_d = cpos_q;
					end
					expop_d = 1'b0;
				end else if (is_digit) begin
					phase_d  = PH_NUMBER;
					accum_d  = {59'd0, char_s1[3:0]};
					nstart_d = cpos_q;
				end else begin
					sec_v      = 1'b1;
					sec_r.kind = KIND_BAD;
					sec_r.err  = ERR_BAD_CHAR;
					sec_r.epos = pos16(cpos_q);
					sec_r.bad  = char_s1;
					phase_d    = PH_DISCARD;
				end
				cpos_d = pos_inc;
			end
		end

		sec_r.last = 1'b1;
		int_r.last = !sec_v;
		if (emit_int) begin
			slot0 = int_r;
			slot1 = sec_r;
		end else begin
			slot0 = sec_r;
			slot1 = sec_r;
		end
		n_res = {1'b0, emit_int} + {1'b0, sec_v};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			char_s1 <= char_code;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			accum_q  <= '0;
			nstart_q <= '0;
			cpos_q   <= '0;
			expop_q  <= 1'b0;
			gerr_q   <= ERR_NONE;
			gpos_q   <= '0;
		end else if (proc) begin
			phase_q  <= phase_d;
			accum_q  <= accum_d;
			nstart_q <= nstart_d;
			cpos_q   <= cpos_d;
			expop_q  <= expop_d;
			gerr_q   <= gerr_d;
			gpos_q   <= gpos_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 2'd1;
			end
			if (proc) begin
				wr_ptr_q <= wr_ptr_q + n_res;
			end
			count_q <= count_q + (proc ? {1'b0, n_res} : 3'd0) - {2'd0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (proc && n_res != 2'd0) begin
			fifo_q[wr_ptr_q] <= slot0;
		end
		if (proc && n_res == 2'd2) begin
			fifo_q[wr_ptr_q + 2'd1] <= slot1;
		end
	end

	assign out_valid  = (count_q != 3'd0);
	assign token_kind = fifo_q[rd_ptr_q].kind;
	assign is_minus   = fifo_q[rd_ptr_q].minus;
	assign int_value  = fifo_q[rd_ptr_q].value;
	assign token_pos  = fifo_q[rd_ptr_q].pos;
	assign error_code = fifo_q[rd_ptr_q].err;
	assign error_pos  = fifo_q[rd_ptr_q].epos;
	assign bad_char   = fifo_q[rd_ptr_q].bad;
	assign last       = fifo_q[rd_ptr_q].last;

endmodule

// ===== rtl/core/selc_checker.sv =====
module selc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [1:0]  token_kind,
	input logic        is_minus,
	input logic [62:0] int_value,
	input logic [15:0] token_pos,
	input logic [1:0]  error_code,
	input logic [15:0] error_pos,
	input logic [7:0]  bad_char,
	input logic        last
);
	import selc_pkg::*;

	// stalled transaction holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(token_kind) && $stable(int_value)
			&& $stable(token_pos) && $stable(error_code) && $stable(last))
		else $error("output transaction changed while stalled");

	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && token_kind == KIND_END |-> last && int_value == 63'd0 && !is_minus)
		else $error("end token not marked last");

	a_bad_err: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && token_kind == KIND_BAD |->
			error_code == ERR_BAD_CHAR && error_pos == token_pos && last)
		else $error("bad character token malformed");

	a_op_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (token_kind == KIND_OP || token_kind == KIND_INT) |->
			error_code == ERR_NONE && error_pos == 16'd0 && bad_char == 8'd0)
		else $error("token carries error fields");

endmodule

bind sum_expression_lexer_checker_unit selc_checker u_selc_checker (.*);

// ===== tb/sv/sum_expression_lexer_checker_unit_tb.sv =====
module sum_expression_lexer_checker_unit_tb;
	import selc_pkg::*;

	typedef enum logic [1:0] {PH_IDLE, PH_NUMBER, PH_DISCARD} scan_phase_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic        minus;
		logic [62:0] value;
		logic [15:0] pos;
		logic [1:0]  err;
		logic [15:0] epos;
		logic [7:0]  bad;
		logic        fin;
	} token_t;

	class token_scoreboard;
		token_t      pending[$];
		int          errors;
		scan_phase_t phase;
		logic [62:0] accum;
		logic [15:0] num_start;
		logic [15:0] char_pos;
		logic        want_op;
		logic [1:0]  gram_err;
		logic [15:0] gram_err_pos;

		function new();
			errors = 0;
			clear();
		endfunction

		function void clear();
			phase = PH_IDLE;
			accum = '0;
			num_start = '0;
			char_pos = '0;
			want_op = 1'b0;
			gram_err = ERR_NONE;
			gram_err_pos = '0;
		endfunction

		function void add_token(logic [1:0] kind, logic minus, logic [62:0] value,
				logic [15:0] pos, logic [1:0] err, logic [15:0] epos, logic [7:0] bad);
			token_t t;
			t.kind = kind;
			t.minus = minus;
			t.value = value;
			t.pos = pos;
			t.err = err;
			t.epos = epos;
			t.bad = bad;
			t.fin = 1'b0;
			pending.push_back(t);
		endfunction

		function void grammar_fault(logic [1:0] code, logic [15:0] pos);
			if (gram_err == ERR_NONE) begin
				gram_err = code;
				gram_err_pos = pos;
			end
		endfunction

		function void mark_final();
			token_t t;
			t = pending.pop_back();
			t.fin = 1'b1;
			pending.push_back(t);
		endfunction

		function void note_char(logic [7:0] c);
			int          before_cnt;
			logic [15:0] pos;
			logic        digit;
			logic [62:0] d;
			before_cnt = pending.size();
			pos = char_pos;
			digit = (c >= CH_ZERO) && (c <= CH_NINE);
			d = 63'(c - CH_ZERO);
			if (phase == PH_NUMBER) begin
				if (digit) begin
					if (accum > (VALUE_MAX - d) / 63'd10)
						accum = VALUE_MAX;
					else
						accum = accum * 63'd10 + d;
					if (char_pos != 16'hFFFF)
						char_pos++;
					return;
				end
				add_token(KIND_INT, 1'b0, accum, num_start, ERR_NONE, '0, '0);
				if (want_op)
					grammar_fault(ERR_EXP_OP, num_start);
				want_op = 1'b1;
				phase = PH_IDLE;
				accum = '0;
			end
			if (c == CH_END) begin
				if (!want_op)
					grammar_fault(ERR_EXP_INT, pos);
				add_token(KIND_END, 1'b0, '0, pos, gram_err,
					(gram_err != ERR_NONE) ? gram_err_pos : 16'd0, '0);
				mark_final();
				clear();
				return;
			end
			if (phase == PH_DISCARD) begin
			end else if ((c >= CH_TAB && c <= CH_CR) || c == CH_SPACE) begin
			end else if (c == CH_PLUS || c == CH_MINUS) begin
				add_token(KIND_OP, c == CH_MINUS, '0, pos, ERR_NONE, '0, '0);
				if (!want_op)
					grammar_fault(ERR_EXP_INT, pos);
				want_op = 1'b0;
			end else if (digit) begin
				phase = PH_NUMBER;
				accum = d;
				num_start = pos;
			end else begin
				add_token(KIND_BAD, 1'b0, '0, pos, ERR_BAD_CHAR, pos, c);
				phase = PH_DISCARD;
			end
			if (char_pos != 16'hFFFF)
				char_pos++;
			if (pending.size() > before_cnt)
				mark_final();
		endfunction

		function void compare(string name, logic [63:0] want_v, logic [63:0] got_v);
			if (want_v !== got_v) begin
				$error("%s: expected %0d, got %0d", name, want_v, got_v);
				errors++;
			end
		endfunction

		function void check(logic [1:0] kind, logic minus, logic [62:0] value,
				logic [15:0] pos, logic [1:0] err, logic [15:0] epos, logic [7:0] bad,
				logic fin);
			token_t want;
			if (pending.size() == 0) begin
				$error("token with nothing expected: kind %0d pos %0d", kind, pos);
				errors++;
				return;
			end
			want = pending.pop_front();
			compare("token_kind", want.kind, kind);
			compare("is_minus", want.minus, minus);
			compare("int_value", want.value, value);
			compare("token_pos", want.pos, pos);
			compare("error_code", want.err, err);
			compare("error_pos", want.epos, epos);
			compare("bad_char", want.bad, bad);
			compare("last", want.fin, fin);
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  char_code = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  token_kind;
	logic        is_minus;
	logic [62:0] int_value;
	logic [15:0] token_pos;
	logic [1:0]  error_code;
	logic [15:0] error_pos;
	logic [7:0]  bad_char;
	logic        last;

	token_scoreboard sb = new();
	int chars_sent = 0;
	int chars_accepted = 0;
	int burst_left = 0;
	bit held_off = 1'b0;

	sum_expression_lexer_checker_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.char_code(char_code),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.token_kind(token_kind),
		.is_minus(is_minus),
		.int_value(int_value),
		.token_pos(token_pos),
		.error_code(error_code),
		.error_pos(error_pos),
		.bad_char(bad_char),
		.last(last)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				sb.note_char(char_code);
				chars_accepted++;
			end
			if (out_valid && out_ready)
				sb.check(token_kind, is_minus, int_value, token_pos, error_code,
					error_pos, bad_char, last);
		end
	end

	task automatic send_char(input logic [7:0] c);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(1, 4);
			burst_left = ($urandom_range(0, 3) == 0) ? 150 : $urandom_range(1, 24);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		burst_left--;
		in_valid <= 1'b1;
		char_code <= c;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		chars_sent++;
	endtask

	function automatic logic [7:0] pick_ws();
		int k;
		k = $urandom_range(0, 5);
		return (k == 5) ? CH_SPACE : CH_TAB + 8'(k);
	endfunction

	function automatic logic [7:0] pick_bad();
		logic [7:0] c;
		do
			c = 8'($urandom_range(1, 255));
		while ((c >= CH_ZERO && c <= CH_NINE) || (c >= CH_TAB && c <= CH_CR) ||
			c == CH_SPACE || c == CH_PLUS || c == CH_MINUS);
		return c;
	endfunction

	task automatic send_space();
		int n;
		n = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
		repeat (n) send_char(pick_ws());
	endtask

	task automatic send_number();
		int len;
		len = ($urandom_range(0, 5) == 0) ? $urandom_range(17, 22) : $urandom_range(1, 4);
		repeat (len) send_char(CH_ZERO + 8'($urandom_range(0, 9)));
	endtask

	task automatic send_op();
		send_char($urandom_range(0, 1) ? CH_MINUS : CH_PLUS);
	endtask

	task automatic send_expression();
		int terms;
		terms = $urandom_range(1, 5);
		for (int i = 0; i < terms; i++) begin
			send_space();
			if (i != 0) begin
				send_op();
				send_space();
			end
			send_number();
		end
		send_space();
	endtask

	initial begin : receiver
		int mode;
		int span;
		while (!arst_n) @(posedge clk);
		forever begin
			if (!held_off && chars_accepted >= 400) begin
				held_off = 1'b1;
				out_ready <= 1'b0;
				for (int n = 0; n < 300; n++)
					@(posedge clk);
			end
			mode = $urandom_range(0, 3);
			span = $urandom_range(4, 40);
			for (int i = 0; i < span; i++) begin
				case (mode)
					0: out_ready <= 1'b1;
					1: out_ready <= ($urandom_range(0, 3) != 0);
					2: out_ready <= ((i % 3) != 2);
					default: out_ready <= ($urandom_range(0, 3) == 0);
				endcase
				@(posedge clk);
			end
		end
	end

	initial begin : sender
		logic [7:0] opening[] = '{
			CH_END,
			"1", CH_PLUS, CH_END,
			CH_PLUS, "9", CH_SPACE, "9", CH_END,
			"9", CH_SPACE, "0", CH_MINUS, CH_END,
			"3", 8'hFF, "x", CH_PLUS, CH_END,
			CH_TAB, "4", CH_CR, CH_MINUS, 8'h0B, "5", CH_END
		};
		int shape;
		int n;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (opening[i])
			send_char(opening[i]);

		while (chars_sent < 1350) begin
			shape = $urandom_range(0, 8);
			if (shape <= 5) begin
				send_expression();
			end else if (shape == 6) begin
				n = $urandom_range(1, 6);
				repeat (n) begin
					case ($urandom_range(0, 3))
						0: send_number();
						1: send_op();
						2: send_char(pick_ws());
						default: if ($urandom_range(0, 3) == 0) send_char(pick_bad());
					endcase
				end
			end else if (shape == 7) begin
				if ($urandom_range(0, 1))
					send_expression();
				send_char(pick_bad());
				n = $urandom_range(0, 5);
				repeat (n) send_char(8'($urandom_range(1, 255)));
			end else begin
				n = $urandom_range(1, 8);
				repeat (n) send_char(8'($urandom_range(1, 255)));
			end
			send_char(CH_END);
		end

		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (sb.errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	initial begin : watchdog
		#4000000;
		$display("simulation failed");
		$finish;
	end
endmodule

// ===== sum_expression_lexer_checker_unit.f =====
rtl/core/selc_pkg.sv
rtl/core/sum_expression_lexer_checker_unit.sv
rtl/core/selc_checker.sv
tb/sv/sum_expression_lexer_checker_unit_tb.sv
